// ===== hdl/xt_pkg.sv =====
package xt_pkg;

  localparam logic [31:0] DELTA = 32'h9E37_79B9;

  localparam int DEFAULT_MAX_ROUNDS = 64;
  localparam int ROUNDS_W = 7;
  localparam int CFG_INDEX_W = 3;
  localparam logic [ROUNDS_W-1:0] ROUNDS_RESET = 7'd32;

  localparam logic MODE_ENC = 1'b0;
  localparam logic MODE_DEC = 1'b1;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_KEY0,
    REG_KEY1,
    REG_KEY2,
    REG_KEY3,
    REG_ROUNDS
  } reg_index_t;

  typedef logic [3:0][31:0] key_t;

  typedef struct packed {
    logic        mode;
    logic [31:0] left_word;
    logic [31:0] right_word;
  } item_t;

  typedef struct packed {
    logic [31:0] left_result;
    logic [31:0] right_result;
  } result_t;

  // Block in flight between two half-round cells
  typedef struct packed {
    logic        valid;
    logic        dec;
    logic [31:0] v0;
    logic [31:0] v1;
    logic [31:0] sum;
  } cell_state_t;

endpackage

// ===== hdl/xt_regs.sv =====
module xt_regs #(
  parameter int MAX_ROUNDS = xt_pkg::DEFAULT_MAX_ROUNDS
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  input  logic [xt_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  logic [31:0]                          cfg_data,
  output xt_pkg::key_t                         key,
  output logic [$clog2(2*MAX_ROUNDS)-1:0]      entry_idx,
  output logic [31:0]                          dec_sum
);

  localparam int CNT_W = $clog2(MAX_ROUNDS + 1);
  localparam int NW = (CNT_W > xt_pkg::ROUNDS_W) ? CNT_W : xt_pkg::ROUNDS_W;
  localparam int IW = $clog2(2*MAX_ROUNDS);
  localparam logic [NW-1:0] MAX_N = NW'(MAX_ROUNDS);
  localparam logic [NW:0] NCELL_V = (NW+1)'(2*MAX_ROUNDS);

  xt_pkg::key_t                  key_words;
  logic [xt_pkg::ROUNDS_W-1:0]   rounds;
  logic [NW-1:0]                 rounds_ext;
  logic [NW-1:0]                 n_used;
  logic [NW:0]                   entry_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_words <= '0;
      rounds    <= xt_pkg::ROUNDS_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        xt_pkg::REG_KEY0:   key_words[0] <= cfg_data;
        xt_pkg::REG_KEY1:   key_words[1] <= cfg_data;
        xt_pkg::REG_KEY2:   key_words[2] <= cfg_data;
        xt_pkg::REG_KEY3:   key_words[3] <= cfg_data;
        xt_pkg::REG_ROUNDS: rounds       <= cfg_data[xt_pkg::ROUNDS_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the cycle count to 1..MAX_ROUNDS
  always_comb begin
    rounds_ext = NW'(rounds);
    if (rounds_ext == '0) begin
      n_used = NW'(1);
    end else if (rounds_ext > MAX_N) begin
      n_used = MAX_N;
    end else begin
      n_used = rounds_ext;
    end
  end

  // Blocks enter part way down the chain so every block leaves at the last cell
  assign entry_full = NCELL_V - {n_used, 1'b0};
  assign entry_idx  = entry_full[IW-1:0];
  assign dec_sum    = xt_pkg::DELTA * {{(32-NW){1'b0}}, n_used};
  assign key        = key_words;

endmodule

// ===== hdl/xt_cell.sv =====
module xt_cell (
  input  logic                clk,
  input  logic                rst,
  input  logic                advance,
  input  logic                second_half,
  input  logic                load,
  input  xt_pkg::cell_state_t entry,
  input  xt_pkg::cell_state_t prev,
  input  xt_pkg::key_t        key,
  output xt_pkg::cell_state_t cur
);

  xt_pkg::cell_state_t src;
  xt_pkg::cell_state_t cur_next;
  logic                hit_v0;
  logic [1:0]          sel;
  logic [31:0]         from_word;
  logic [31:0]         to_word;
  logic [31:0]         f;
  logic [31:0]         new_word;

  function automatic logic [31:0] mix(input logic [31:0] x);
    return ((x << 4) ^ (x >> 5)) + x;
  endfunction

  always_comb begin
    src = load ? entry : prev;
    // First half of an encrypt cycle and second half of a decrypt cycle update v0
    hit_v0    = ~(second_half ^ src.dec);
    sel       = hit_v0 ? src.sum[1:0] : src.sum[12:11];
    from_word = hit_v0 ? src.v1 : src.v0;
    to_word   = hit_v0 ? src.v0 : src.v1;
    f         = mix(from_word) ^ (src.sum + key[sel]);
    new_word  = (src.dec == xt_pkg::MODE_DEC) ? (to_word - f) : (to_word + f);

    cur_next = src;
    if (hit_v0) begin
      cur_next.v0 = new_word;
    end else begin
      cur_next.v1 = new_word;
    end
    if (!second_half) begin
      cur_next.sum = (src.dec == xt_pkg::MODE_DEC) ? (src.sum - xt_pkg::DELTA)
                                                   : (src.sum + xt_pkg::DELTA);
    end
  end

  // Only the valid flag needs a reset; the payload follows it
  always_ff @(posedge clk) begin
    if (rst) begin
      cur.valid <= 1'b0;
    end else if (advance) begin
      cur.valid <= cur_next.valid;
    end
    if (advance) begin
      cur.dec <= cur_next.dec;
      cur.v0  <= cur_next.v0;
      cur.v1  <= cur_next.v1;
      cur.sum <= cur_next.sum;
    end
  end

endmodule

// ===== hdl/xtea_block_cipher.sv =====
// XTEA on 64-bit blocks: a chain of 2*MAX_ROUNDS half-round cells, one half-round a cell.
// Blocks enter part way down the chain as set by n, the clamped round_count (32 after reset),
// and the result is registered behind the last cell of the chain.
// Throughput: one block a cycle while the result side keeps up; a stalled result holds the chain.
// Reset (rst, synchronous): key words to zero, round_count to 32, chain and result emptied.
module xtea_block_cipher #(
  parameter int MAX_ROUNDS = xt_pkg::DEFAULT_MAX_ROUNDS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [xt_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_data,
  input  logic                           item_valid,
  output logic                           item_stall,
  input  xt_pkg::item_t                  item,
  output logic                           result_valid,
  input  logic                           result_stall,
  output xt_pkg::result_t                result
);

  localparam int NCELL = 2*MAX_ROUNDS;
  localparam int IW = $clog2(NCELL);

  xt_pkg::key_t        key;
  logic [IW-1:0]       entry_idx;
  logic [31:0]         dec_sum;
  logic                advance;
  logic                item_fire;
  xt_pkg::cell_state_t entry;
  xt_pkg::cell_state_t cell_in [NCELL];
  xt_pkg::cell_state_t cell_q  [NCELL];
  logic [NCELL-1:0]    load;

  assign cfg_ready = 1'b1;

  xt_regs #(
    .MAX_ROUNDS(MAX_ROUNDS)
  ) u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .key       (key),
    .entry_idx (entry_idx),
    .dec_sum   (dec_sum)
  );

  // Whole chain moves together; hold it while a finished result waits
  assign advance    = !result_valid || !result_stall;
  assign item_stall = !advance;
  assign item_fire  = item_valid && advance;

  always_comb begin
    entry.valid = 1'b1;
    entry.dec   = item.mode;
    entry.v0    = item.left_word;
    entry.v1    = item.right_word;
    entry.sum   = (item.mode == xt_pkg::MODE_DEC) ? dec_sum : 32'd0;
  end

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign cell_in[i] = '0;
    end else begin : g_link
      assign cell_in[i] = cell_q[i-1];
    end

    assign load[i] = item_fire && (entry_idx == IW'(i));

    xt_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .advance     (advance),
      .second_half (1'(i % 2)),
      .load        (load[i]),
      .entry       (entry),
      .prev        (cell_in[i]),
      .key         (key),
      .cur         (cell_q[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= cell_q[NCELL-1].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result.left_result  <= cell_q[NCELL-1].v0;
      result.right_result <= cell_q[NCELL-1].v1;
    end
  end

endmodule

// ===== tb/xtea_block_cipher_tb.sv =====
`timescale 1ns / 1ps

module xtea_block_cipher_tb;

  localparam int MAX_FAULT_REPORTS = 10;
  localparam int LAST_INDEX = (1 << xt_pkg::CFG_INDEX_W) - 1;
  localparam int FIRST_UNUSED_INDEX = int'(xt_pkg::REG_ROUNDS) + 1;
  localparam int MAX_LATENCY = 2 * xt_pkg::DEFAULT_MAX_ROUNDS + 1;

  typedef enum {
    STALL_NONE,
    STALL_RANDOM,
    STALL_RUNS,
    STALL_TOGGLE
  } stall_style_t;

  // Mirror of the key and round count, plus the blocks still owed by the cipher
  class xtea_ledger;
    xt_pkg::key_t                key;
    logic [xt_pkg::ROUNDS_W-1:0] rounds;
    xt_pkg::result_t             expected_blocks[$];
    int                          faults;

    function new();
      key = '0;
      rounds = xt_pkg::ROUNDS_RESET;
      faults = 0;
    endfunction

    function void write_reg(logic [xt_pkg::CFG_INDEX_W-1:0] idx, logic [31:0] data);
      case (idx)
        xt_pkg::REG_KEY0:   key[0] = data;
        xt_pkg::REG_KEY1:   key[1] = data;
        xt_pkg::REG_KEY2:   key[2] = data;
        xt_pkg::REG_KEY3:   key[3] = data;
        xt_pkg::REG_ROUNDS: rounds = data[xt_pkg::ROUNDS_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [31:0] mix(logic [31:0] x);
      return ((x << 4) ^ (x >> 5)) + x;
    endfunction

    function xt_pkg::result_t cipher_block(xt_pkg::item_t b);
      int              n;
      logic [31:0]     v0;
      logic [31:0]     v1;
      logic [31:0]     sum;
      xt_pkg::result_t r;
      n = int'(rounds);
      if (n == 0) n = 1;
      if (n > xt_pkg::DEFAULT_MAX_ROUNDS) n = xt_pkg::DEFAULT_MAX_ROUNDS;
      v0 = b.left_word;
      v1 = b.right_word;
      if (b.mode == xt_pkg::MODE_ENC) begin
        sum = '0;
        for (int i = 0; i < n; i++) begin
          v0 = v0 + (mix(v1) ^ (sum + key[sum[1:0]]));
          sum = sum + xt_pkg::DELTA;
          v1 = v1 + (mix(v0) ^ (sum + key[sum[12:11]]));
        end
      end else begin
        sum = xt_pkg::DELTA * 32'(n);
        for (int i = 0; i < n; i++) begin
          v1 = v1 - (mix(v0) ^ (sum + key[sum[12:11]]));
          sum = sum - xt_pkg::DELTA;
          v0 = v0 - (mix(v1) ^ (sum + key[sum[1:0]]));
        end
      end
      r.left_result = v0;
      r.right_result = v1;
      return r;
    endfunction

    function void note_block(xt_pkg::item_t b);
      expected_blocks.push_back(cipher_block(b));
    endfunction

    function void check_block(xt_pkg::result_t got);
      xt_pkg::result_t want;
      if (expected_blocks.size() == 0) begin
        faults++;
        if (faults <= MAX_FAULT_REPORTS)
          $display("unexpected result %h_%h", got.left_result, got.right_result);
        return;
      end
      want = expected_blocks.pop_front();
      if (got.left_result !== want.left_result || got.right_result !== want.right_result) begin
        faults++;
        if (faults <= MAX_FAULT_REPORTS)
          $display("block mismatch: expected %h_%h got %h_%h",
                   want.left_result, want.right_result, got.left_result, got.right_result);
      end
    endfunction

    function int outstanding();
      return expected_blocks.size();
    endfunction
  endclass

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [xt_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [31:0]                    cfg_data = '0;
  logic                           item_valid = 1'b0;
  logic                           item_stall;
  xt_pkg::item_t                  item = '0;
  logic                           result_valid;
  logic                           result_stall = 1'b0;
  xt_pkg::result_t                result;

  xtea_ledger   ledger = new();
  int           burst_left = 0;
  int           sender_gap_max = 0;
  stall_style_t stall_style = STALL_NONE;
  int           stretch_left = 0;
  int           run_left = 0;
  logic         run_level = 1'b0;

  xtea_block_cipher dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver back-pressure: switch style every so often, including quiet stretches
  always @(posedge clk) begin
    if (stretch_left == 0) begin
      stall_style = stall_style_t'($urandom_range(0, 3));
      stretch_left = $urandom_range(16, 200);
    end
    stretch_left--;
    case (stall_style)
      STALL_NONE:   result_stall <= 1'b0;
      STALL_RANDOM: result_stall <= ($urandom_range(0, 3) == 0);
      STALL_RUNS: begin
        if (run_left == 0) begin
          run_level = !run_level;
          run_left = run_level ? $urandom_range(1, 20) : $urandom_range(1, 12);
        end
        run_left--;
        result_stall <= run_level;
      end
      default:      result_stall <= !result_stall;
    endcase
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall)
      ledger.check_block(result);
  end

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 15))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h8000_0000;
      3:       return 32'h7FFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  function automatic xt_pkg::item_t random_block();
    xt_pkg::item_t b;
    b.mode = ($urandom_range(0, 1) == 0) ? xt_pkg::MODE_ENC : xt_pkg::MODE_DEC;
    b.left_word = pick_word();
    b.right_word = pick_word();
    return b;
  endfunction

  function automatic xt_pkg::key_t random_key();
    xt_pkg::key_t k;
    for (int i = 0; i < 4; i++) k[i] = pick_word();
    return k;
  endfunction

  task automatic write_reg(input int idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= xt_pkg::CFG_INDEX_W'(idx);
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    ledger.write_reg(xt_pkg::CFG_INDEX_W'(idx), data);
  endtask

  // Hold valid across back-to-back writes; drop it once the set is in
  task automatic load_config(input xt_pkg::key_t k, input logic [31:0] rounds_word,
                             input bit poke_unused);
    for (int i = 0; i < 4; i++) write_reg(int'(xt_pkg::REG_KEY0) + i, k[i]);
    write_reg(int'(xt_pkg::REG_ROUNDS), rounds_word);
    if (poke_unused)
      for (int j = FIRST_UNUSED_INDEX; j <= LAST_INDEX; j++) write_reg(j, $urandom());
    cfg_valid <= 1'b0;
  endtask

  task automatic send_block(input xt_pkg::item_t b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, sender_gap_max);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        item_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    item <= b;
    item_valid <= 1'b1;
    do @(posedge clk); while (item_stall);
    ledger.note_block(b);
  endtask

  task automatic send_pair(input logic [31:0] l, input logic [31:0] r);
    send_block('{xt_pkg::MODE_ENC, l, r});
    send_block('{xt_pkg::MODE_DEC, l, r});
  endtask

  // Encrypt, then feed the predicted ciphertext straight back for decryption
  task automatic send_round_trip();
    xt_pkg::item_t   b;
    xt_pkg::result_t c;
    b = random_block();
    b.mode = xt_pkg::MODE_ENC;
    c = ledger.cipher_block(b);
    send_block(b);
    send_block('{xt_pkg::MODE_DEC, c.left_result, c.right_result});
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    while (ledger.outstanding() != 0) @(posedge clk);
  endtask

  initial begin
    xt_pkg::key_t k;
    logic [31:0]  rounds_word;
    int           sent;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Reset key and round count
    sender_gap_max = 3;
    send_pair(32'h0000_0000, 32'h0000_0000);
    send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_pair(32'h8000_0000, 32'h7FFF_FFFF);
    send_pair(32'h0123_4567, 32'h89AB_CDEF);
    drain();

    load_config({4{32'hFFFF_FFFF}}, 32'd1, 1'b0);
    send_pair(32'h0000_0000, 32'hFFFF_FFFF);
    drain();

    load_config({32'h0C0D_0E0F, 32'h0809_0A0B, 32'h0405_0607, 32'h0001_0203}, 32'd64, 1'b0);
    send_pair(32'h4142_4344, 32'h4546_4748);
    drain();

    // Zero round count once the upper bits are dropped: clamped to a single round
    load_config(random_key(), 32'hFFFF_FF80, 1'b0);
    send_pair(pick_word(), pick_word());
    drain();

    // Widest round count clamps to the maximum; unused indexes must not disturb the key
    load_config(random_key(), 32'h0000_007F, 1'b1);
    send_pair(pick_word(), pick_word());
    drain();

    load_config(random_key(), 32'hABCD_0041, 1'b0);
    send_pair(pick_word(), pick_word());
    drain();

    for (int p = 0; p < 12; p++) begin
      rounds_word = $urandom_range(1, xt_pkg::DEFAULT_MAX_ROUNDS);
      case ($urandom_range(0, 5))
        0: rounds_word = 32'd0;
        1: rounds_word = $urandom_range(xt_pkg::DEFAULT_MAX_ROUNDS + 1, 127);
        2: rounds_word = rounds_word | ($urandom() & 32'hFFFF_FF80);
        default: ;
      endcase
      k = random_key();
      case ($urandom_range(0, 2))
        0:       sender_gap_max = 0;
        1:       sender_gap_max = 3;
        default: sender_gap_max = 40;
      endcase
      load_config(k, rounds_word, $urandom_range(0, 3) == 0);
      sent = 0;
      while (sent < 75) begin
        if ($urandom_range(0, 3) == 0) begin
          send_round_trip();
          sent += 2;
        end else begin
          send_block(random_block());
          sent++;
        end
      end
      drain();
    end

    // Catch any stray result that trails the last expected one
    repeat (MAX_LATENCY + 10) @(posedge clk);
    ledger.faults += ledger.outstanding();
    if (ledger.faults == 0)
      $display("xtea_block_cipher_tb passed");
    else
      $display("xtea_block_cipher_tb failed");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("xtea_block_cipher_tb failed");
    $finish;
  end

endmodule
